### design/assert_macros.svh
// assertion macros used by the decoder's top-level rtl file
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER_CLK(name, clk, rst_n, prop)
`endif

`endif

### design/eed_pkg.sv
// types and character constants for the echo escape decoder
// no dependencies
`default_nettype none

package eed_pkg;

    localparam int MaxResults = 3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_STOP  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_V  = 8'h76;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] status;
        logic       message_end;
    } t_result;

    typedef struct packed {
        t_result [MaxResults-1:0] res;
        logic [1:0]               count;
    } t_decode;

endpackage

`default_nettype wire

### design/echo_escape_decoder.sv
// top level of the echo escape decoder: input handshake and result buffer
// depends on eed_pkg, eed_decode and assert_macros.svh
//
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_ch i_has_char i_arg_end i_last_arg
// result    out        o_valid / i_stall  o_out_byte o_has_byte o_status
//                                         o_message_end o_run_last
//
// an item is decoded in the cycle it is taken; its up to three results are
// written to the result buffer at that edge and leave one per cycle after it
// while i_stall is low; an item with results holds the result port until
// its last result leaves; the next item is taken on the edge it leaves
// o_stall follows i_stall combinationally while the last buffered result waits
// synchronous active-low reset empties the buffer and returns to normal mode
`default_nettype none
`include "assert_macros.svh"

module echo_escape_decoder #(
    parameter int MAX_OCTAL_DIGITS = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_has_char,
    input  wire logic       i_arg_end,
    input  wire logic       i_last_arg,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic [1:0]      o_status,
    output logic            o_message_end,
    output logic            o_run_last
);
    import eed_pkg::*;

    t_decode                  w_dec;
    t_result [MaxResults-1:0] r_res;
    t_result                  w_cur;
    logic [1:0]               r_cnt;
    logic [1:0]               r_idx;
    logic                     w_last;
    logic                     w_out_xfer;
    logic                     w_free;
    logic                     w_in_xfer;

    eed_decode #(
        .MAX_OCTAL_DIGITS(MAX_OCTAL_DIGITS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_xfer     (w_in_xfer),
        .i_ch       (i_ch),
        .i_has_char (i_has_char),
        .i_arg_end  (i_arg_end),
        .i_last_arg (i_last_arg),
        .o_dec      (w_dec)
    );

    assign w_last     = (r_idx == (r_cnt - 2'd1));
    assign o_valid    = (r_cnt != 2'd0);
    assign w_out_xfer = o_valid && !i_stall;
    assign w_free     = (r_cnt == 2'd0) || (w_out_xfer && w_last);
    assign o_stall    = !w_free;
    assign w_in_xfer  = i_valid && w_free;

    assign w_cur         = r_res[r_idx];
    assign o_out_byte    = w_cur.out_byte;
    assign o_has_byte    = w_cur.has_byte;
    assign o_status      = w_cur.status;
    assign o_message_end = w_cur.message_end;
    assign o_run_last    = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (w_in_xfer) begin
            r_cnt <= w_dec.count;
            r_idx <= '0;
        end else if (w_out_xfer) begin
            if (w_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_res <= w_dec.res;
        end
    end

    `ASSERT_CLK(a_idx_in_range, i_clk, i_rst_n, o_valid |-> (r_idx < r_cnt))
    `ASSERT_CLK(a_end_is_last, i_clk, i_rst_n, (o_valid && o_message_end) |-> o_run_last)
    `ASSERT_CLK(a_nobyte_has_status, i_clk, i_rst_n, (o_valid && !o_has_byte) |-> (o_status != STATUS_OK))
    `ASSERT_NEVER_CLK(a_no_take_while_busy, i_clk, i_rst_n, w_in_xfer && o_valid && !(w_last && !i_stall))
    `ASSERT_CLK(a_idx_steps, i_clk, i_rst_n, (o_valid && i_stall) |=> ($stable(r_idx) && $stable(r_cnt)))

endmodule

`default_nettype wire

### design/eed_decode.sv
// escape decoding state and per-item result list
// depends on eed_pkg
`default_nettype none

module eed_decode #(
    parameter int MAX_OCTAL_DIGITS = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_xfer,
    input  wire logic [7:0]     i_ch,
    input  wire logic           i_has_char,
    input  wire logic           i_arg_end,
    input  wire logic           i_last_arg,
    output eed_pkg::t_decode    o_dec
);
    import eed_pkg::*;

    localparam logic [2:0] MaxDigits = 3'(MAX_OCTAL_DIGITS);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_OCTAL,
        MODE_DROP
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_oct, n_oct;
    logic [2:0] r_cnt, n_cnt;

    t_result    cand [4];
    logic [3:0] cand_v;

    function automatic t_result mk(input logic [7:0] b, input logic h,
                                   input logic [1:0] s, input logic e);
        t_result r;
        r.out_byte    = b;
        r.has_byte    = h;
        r.status      = s;
        r.message_end = e;
        return r;
    endfunction

    always_comb begin
        n_mode = r_mode;
        n_oct  = r_oct;
        n_cnt  = r_cnt;
        cand_v = '0;
        for (int k = 0; k < 4; k++) begin
            cand[k] = '0;
        end

        // character phase: slot 0 octal flush, slot 1 character result
        if (i_has_char) begin
            case (r_mode)
                MODE_NORMAL: begin
                    if (i_ch == CH_BSL) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(i_ch, 1'b1, STATUS_OK, 1'b0);
                    end
                end
                MODE_ESCAPE: begin
                    n_mode    = MODE_NORMAL;
                    cand_v[1] = 1'b1;
                    case (i_ch)
                        CH_LC_A: cand[1] = mk(CH_BEL, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_B: cand[1] = mk(CH_BS,  1'b1, STATUS_OK, 1'b0);
                        CH_LC_F: cand[1] = mk(CH_FF,  1'b1, STATUS_OK, 1'b0);
                        CH_LC_N: cand[1] = mk(CH_LF,  1'b1, STATUS_OK, 1'b0);
                        CH_LC_R: cand[1] = mk(CH_CR,  1'b1, STATUS_OK, 1'b0);
                        CH_LC_T: cand[1] = mk(CH_HT,  1'b1, STATUS_OK, 1'b0);
                        CH_LC_V: cand[1] = mk(CH_VT,  1'b1, STATUS_OK, 1'b0);
                        CH_BSL:  cand[1] = mk(CH_BSL, 1'b1, STATUS_OK, 1'b0);
                        CH_ZERO: begin
                            n_oct = '0;
                            if (MaxDigits <= 3'd1) begin
                                cand[1] = mk(8'h00, 1'b1, STATUS_OK, 1'b0);
                                n_cnt   = '0;
                            end else begin
                                cand_v[1] = 1'b0;
                                n_cnt     = 3'd1;
                                n_mode    = MODE_OCTAL;
                            end
                        end
                        CH_LC_C: begin
                            cand[1] = mk(8'h00, 1'b0, STATUS_STOP, 1'b1);
                            n_mode  = MODE_DROP;
                        end
                        default: begin
                            cand[1] = mk(8'h00, 1'b0, STATUS_ERROR, 1'b1);
                            n_mode  = MODE_DROP;
                        end
                    endcase
                end
                MODE_OCTAL: begin
                    if (i_ch inside {[CH_ZERO:CH_SEVEN]}) begin
                        n_oct = {r_oct[4:0], i_ch[2:0]};
                        n_cnt = r_cnt + 3'd1;
                        if (n_cnt >= MaxDigits) begin
                            cand_v[1] = 1'b1;
                            cand[1]   = mk(n_oct, 1'b1, STATUS_OK, 1'b0);
                            n_mode    = MODE_NORMAL;
                            n_oct     = '0;
                            n_cnt     = '0;
                        end
                    end else begin
                        cand_v[0] = 1'b1;
                        cand[0]   = mk(r_oct, 1'b1, STATUS_OK, 1'b0);
                        n_oct     = '0;
                        n_cnt     = '0;
                        if (i_ch == CH_BSL) begin
                            n_mode = MODE_ESCAPE;
                        end else begin
                            n_mode    = MODE_NORMAL;
                            cand_v[1] = 1'b1;
                            cand[1]   = mk(i_ch, 1'b1, STATUS_OK, 1'b0);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // argument end phase: slot 2 pending flush, slot 3 separator
        if (i_arg_end) begin
            if (n_mode == MODE_DROP) begin
                if (i_last_arg) begin
                    n_mode = MODE_NORMAL;
                end
            end else begin
                if (n_mode == MODE_ESCAPE) begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(CH_BSL, 1'b1, STATUS_OK, 1'b0);
                end else if (n_mode == MODE_OCTAL) begin
                    cand_v[2] = 1'b1;
                    cand[2]   = mk(n_oct, 1'b1, STATUS_OK, 1'b0);
                end
                n_mode    = MODE_NORMAL;
                n_oct     = '0;
                n_cnt     = '0;
                cand_v[3] = 1'b1;
                if (i_last_arg) begin
                    cand[3] = mk(CH_LF, 1'b1, STATUS_OK, 1'b1);
                end else begin
                    cand[3] = mk(CH_SPACE, 1'b1, STATUS_OK, 1'b0);
                end
            end
        end
    end

    // pack the candidates in order
    always_comb begin
        o_dec = '0;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k] && (o_dec.count != 2'd3)) begin
                o_dec.res[o_dec.count] = cand[k];
                o_dec.count            = o_dec.count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_oct  <= '0;
            r_cnt  <= '0;
        end else if (i_xfer) begin
            r_mode <= n_mode;
            r_oct  <= n_oct;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_echo_escape_decoder.sv
// self-checking testbench for echo_escape_decoder: a directed message set, then random
// messages and noise, with random idling on both channels; depends on eed_pkg and the rtl
`timescale 1ns / 100ps

module tb_echo_escape_decoder;
    import eed_pkg::*;

    localparam int OCTAL_DIGITS = 4;
    localparam logic [2:0] OCT_MAX = 3'(OCTAL_DIGITS);
    localparam logic [7:0] CH_LC_Q = 8'h71;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] ESC_KEYS [8] = '{CH_LC_A, CH_LC_B, CH_LC_F, CH_LC_N,
                                            CH_LC_R, CH_LC_T, CH_LC_V, CH_BSL};

    typedef enum logic [1:0] {DEC_NORMAL, DEC_ESCAPE, DEC_OCTAL, DEC_DROP} t_dec_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       arg_end;
        logic       last_arg;
    } t_char_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] status;
        logic       message_end;
        logic       run_last;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_ch = 8'h00;
    logic       i_has_char = 1'b0;
    logic       i_arg_end = 1'b0;
    logic       i_last_arg = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic [1:0] o_status;
    logic       o_message_end;
    logic       o_run_last;

    t_char_item pending[$];
    t_char_item cur_item;
    t_decoded   expected_out[$];
    t_dec_mode  dec_mode = DEC_NORMAL;
    logic [7:0] oct_val = 8'h00;
    logic [2:0] oct_digits = 3'd0;

    int  n_sent = 0;
    int  n_results = 0;
    int  n_messages = 0;
    int  n_aborts = 0;
    int  n_errors = 0;
    int  send_gap = 0;
    int  stall_gap = 0;
    bit  idle_on = 1'b1;

    echo_escape_decoder #(
        .MAX_OCTAL_DIGITS(OCTAL_DIGITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_has_char   (i_has_char),
        .i_arg_end    (i_arg_end),
        .i_last_arg   (i_last_arg),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_has_byte   (o_has_byte),
        .o_status     (o_status),
        .o_message_end(o_message_end),
        .o_run_last   (o_run_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic emit(input logic [7:0] b, input logic h, input logic [1:0] st,
                        input logic me);
        t_decoded r;
        r.out_byte    = b;
        r.has_byte    = h;
        r.status      = st;
        r.message_end = me;
        r.run_last    = 1'b0;
        expected_out.push_back(r);
    endtask

    task automatic plain_char(input logic [7:0] c);
        if (c == CH_BSL) dec_mode = DEC_ESCAPE;
        else emit(c, 1'b1, STATUS_OK, 1'b0);
    endtask

    task automatic decode_item(input t_char_item it);
        int       first;
        t_decoded r;
        first = expected_out.size();
        if (it.has_char) begin
            case (dec_mode)
                DEC_NORMAL: plain_char(it.ch);
                DEC_ESCAPE: begin
                    dec_mode = DEC_NORMAL;
                    case (it.ch)
                        CH_LC_A: emit(CH_BEL, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_B: emit(CH_BS, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_F: emit(CH_FF, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_N: emit(CH_LF, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_R: emit(CH_CR, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_T: emit(CH_HT, 1'b1, STATUS_OK, 1'b0);
                        CH_LC_V: emit(CH_VT, 1'b1, STATUS_OK, 1'b0);
                        CH_BSL:  emit(CH_BSL, 1'b1, STATUS_OK, 1'b0);
                        CH_ZERO: begin
                            oct_val    = 8'h00;
                            oct_digits = 3'd1;
                            if (oct_digits >= OCT_MAX) begin
                                emit(8'h00, 1'b1, STATUS_OK, 1'b0);
                                oct_digits = 3'd0;
                            end else begin
                                dec_mode = DEC_OCTAL;
                            end
                        end
                        CH_LC_C: begin
                            emit(8'h00, 1'b0, STATUS_STOP, 1'b1);
                            dec_mode = DEC_DROP;
                        end
                        default: begin
                            emit(8'h00, 1'b0, STATUS_ERROR, 1'b1);
                            dec_mode = DEC_DROP;
                        end
                    endcase
                end
                DEC_OCTAL: begin
                    if (it.ch >= CH_ZERO && it.ch <= CH_SEVEN) begin
                        oct_val    = {oct_val[4:0], it.ch[2:0]};
                        oct_digits = oct_digits + 3'd1;
                        if (oct_digits >= OCT_MAX) begin
                            emit(oct_val, 1'b1, STATUS_OK, 1'b0);
                            dec_mode   = DEC_NORMAL;
                            oct_val    = 8'h00;
                            oct_digits = 3'd0;
                        end
                    end else begin
                        emit(oct_val, 1'b1, STATUS_OK, 1'b0);
                        dec_mode   = DEC_NORMAL;
                        oct_val    = 8'h00;
                        oct_digits = 3'd0;
                        plain_char(it.ch);
                    end
                end
                default: ;
            endcase
        end
        if (it.arg_end) begin
            if (dec_mode == DEC_DROP) begin
                if (it.last_arg) dec_mode = DEC_NORMAL;
            end else begin
                if (dec_mode == DEC_ESCAPE) emit(CH_BSL, 1'b1, STATUS_OK, 1'b0);
                else if (dec_mode == DEC_OCTAL) emit(oct_val, 1'b1, STATUS_OK, 1'b0);
                dec_mode   = DEC_NORMAL;
                oct_val    = 8'h00;
                oct_digits = 3'd0;
                if (it.last_arg) emit(CH_LF, 1'b1, STATUS_OK, 1'b1);
                else emit(CH_SPACE, 1'b1, STATUS_OK, 1'b0);
            end
        end
        if (expected_out.size() > first) begin
            r = expected_out.pop_back();
            r.run_last = 1'b1;
            expected_out.push_back(r);
        end
    endtask

    task automatic queue_item(input logic [7:0] c, input logic h, input logic ae,
                              input logic la);
        t_char_item it;
        it.ch       = c;
        it.has_char = h;
        it.arg_end  = ae;
        it.last_arg = la;
        pending.push_back(it);
    endtask

    task automatic gen_message();
        int         n_args;
        int         n_tok;
        int         kind;
        int         arg_start;
        logic [7:0] c;
        t_char_item tail;
        n_args = $urandom_range(1, 4);
        for (int a = 0; a < n_args; a++) begin
            arg_start = pending.size();
            n_tok = $urandom_range(0, 5);
            for (int t = 0; t < n_tok; t++) begin
                kind = $urandom_range(0, 19);
                if (kind < 8) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_BSL) c = CH_SPACE;
                    queue_item(c, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                end else if (kind < 13) begin
                    queue_item(CH_BSL, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                    queue_item(ESC_KEYS[$urandom_range(0, 7)], 1'b1, 1'b0,
                               1'($urandom_range(0, 1)));
                end else if (kind < 17) begin
                    queue_item(CH_BSL, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                    queue_item(CH_ZERO, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 9) == 0) begin
                            c = CH_EIGHT + 8'($urandom_range(0, 1));
                        end else begin
                            c = CH_ZERO + 8'($urandom_range(0, 7));
                        end
                        queue_item(c, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                    end
                end else if (kind == 17) begin
                    queue_item(CH_BSL, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                end else if (kind == 18) begin
                    queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                               1'($urandom_range(0, 1)));
                end else begin
                    queue_item(CH_BSL, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 1) == 0) begin
                        c = CH_LC_C;
                    end else begin
                        c = 8'($urandom_range(0, 255));
                        foreach (ESC_KEYS[k]) if (c == ESC_KEYS[k]) c = CH_LC_Q;
                        if (c == CH_ZERO || c == CH_LC_C) c = CH_LC_Q;
                    end
                    queue_item(c, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                end
            end
            if (pending.size() == arg_start || $urandom_range(0, 3) == 0) begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, a == n_args - 1);
            end else begin
                tail = pending.pop_back();
                tail.arg_end  = 1'b1;
                tail.last_arg = (a == n_args - 1);
                pending.push_back(tail);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            n_errors++;
        end
    endtask

    // input side: a transfer feeds the predictor, then the next item or an idle burst
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                decode_item(cur_item);
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (idle_on && pending.size() > 0 && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    i_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    cur_item = pending.pop_front();
                    i_ch       <= cur_item.ch;
                    i_has_char <= cur_item.has_char;
                    i_arg_end  <= cur_item.arg_end;
                    i_last_arg <= cur_item.last_arg;
                    i_valid    <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin : result_monitor
        t_decoded want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_out.size() == 0) begin
                    $error("unexpected result transfer: out_byte %0h status %0d",
                           o_out_byte, o_status);
                    n_errors++;
                end else begin
                    want = expected_out.pop_front();
                    check_field("out_byte", want.out_byte, o_out_byte);
                    check_field("has_byte", 8'(want.has_byte), 8'(o_has_byte));
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("message_end", 8'(want.message_end), 8'(o_message_end));
                    check_field("run_last", 8'(want.run_last), 8'(o_run_last));
                    if (want.message_end) n_messages++;
                    if (want.status != STATUS_OK) n_aborts++;
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_gap = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int target;
        // escapes, last_arg on an item without arg_end
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_A, 1'b1, 1'b0, 1'b1);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_B, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_F, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_N, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_R, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_T, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_V, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_BSL, 1'b1, 1'b0, 1'b0);
        // full-length octal wraps to 8 bits
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_ZERO, 1'b1, 1'b0, 1'b0);
        queue_item(CH_SEVEN, 1'b1, 1'b0, 1'b0); queue_item(CH_SEVEN, 1'b1, 1'b0, 1'b0);
        queue_item(CH_SEVEN, 1'b1, 1'b0, 1'b0);
        // digit 8 ends the octal value, then octal and lone backslash at argument end
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_ZERO, 1'b1, 1'b0, 1'b0);
        queue_item(CH_EIGHT, 1'b1, 1'b1, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_ZERO, 1'b1, 1'b1, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b1, 1'b0);
        // empty item, empty argument
        queue_item(8'h00, 1'b0, 1'b0, 1'b1);
        queue_item(8'hFF, 1'b0, 1'b1, 1'b0);
        // octal ended by a new escape that stops, then drop to the last argument
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_ZERO, 1'b1, 1'b0, 1'b0);
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(CH_LC_C, 1'b1, 1'b1, 1'b1);
        // unknown escape, then a plain message with extreme bytes
        queue_item(CH_BSL, 1'b1, 1'b0, 1'b0); queue_item(8'hFF, 1'b1, 1'b1, 1'b1);
        queue_item(8'hFF, 1'b1, 1'b0, 1'b0); queue_item(8'h00, 1'b1, 1'b1, 1'b1);

        while (pending.size() < 215) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                gen_message();
            end
        end
        target = pending.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_sent < target - 40) @(posedge i_clk);
        idle_on = 1'b0;
        while (n_sent < target) @(posedge i_clk);
        while (expected_out.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("Summary: %0d input transfers, %0d result transfers checked", n_sent,
                 n_results);
        $display("Summary: %0d messages ended, %0d of them by stop or bad escape",
                 n_messages, n_aborts);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d items sent, %0d results still expected", n_sent,
                 expected_out.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
